// ===== hw/rtl/swld_pkg.sv =====
// ----------------------------------------------------------------------------
// swld_pkg
// shared types and constants of the sync word length deframer
// ----------------------------------------------------------------------------
package swld_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned OUT_DATA_W = 40;

    // sync word, oldest byte in the high bits
    localparam logic [31:0] SYNC_WORD = 32'hDADB_DCDD;

    // bytes held in the window before a compare is made
    localparam logic [1:0] WIN_FULL = 2'd3;

    // last header byte index
    localparam logic [1:0] HDR_LAST = 2'd3;

    // header byte positions
    localparam logic [1:0] HDR_FTYPE  = 2'd0;
    localparam logic [1:0] HDR_PTYPE  = 2'd1;
    localparam logic [1:0] HDR_LEN_LO = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    // one result request from the core to the output register
    typedef struct packed {
        logic                valid;
        logic                empty;
        logic                last;
        logic [BYTE_W-1:0]   payload;
        logic [BYTE_W-1:0]   ftype;
        logic [BYTE_W-1:0]   ptype;
        logic [LEN_W-1:0]    length;
    } t_result;

endpackage

// ===== hw/rtl/swld_in_stage.sv =====
// ----------------------------------------------------------------------------
// swld_in_stage
// input register holding one received byte until the core consumes it
// ----------------------------------------------------------------------------
module swld_in_stage
    import swld_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_advance,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // byte register
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ===== hw/rtl/swld_core.sv =====
// ----------------------------------------------------------------------------
// swld_core
// sync hunt, header capture and payload count, one byte per cycle in which i_fire is high
// ----------------------------------------------------------------------------
module swld_core
    import swld_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [BYTE_W-1:0] i_byte,
    output t_result           o_res
);

    t_phase            r_phase,   n_phase;
    logic [23:0]       r_window,  n_window;
    logic [1:0]        r_win_cnt, n_win_cnt;
    logic [1:0]        r_hdr_cnt, n_hdr_cnt;
    logic [BYTE_W-1:0] r_ftype,   n_ftype;
    logic [BYTE_W-1:0] r_ptype,   n_ptype;
    logic [LEN_W-1:0]  r_length,  n_length;
    logic [LEN_W-1:0]  r_remain,  n_remain;

    // step logic
    always_comb begin
        n_phase   = r_phase;
        n_window  = r_window;
        n_win_cnt = r_win_cnt;
        n_hdr_cnt = r_hdr_cnt;
        n_ftype   = r_ftype;
        n_ptype   = r_ptype;
        n_length  = r_length;
        n_remain  = r_remain;
        o_res     = '0;
        o_res.ftype  = r_ftype;
        o_res.ptype  = r_ptype;
        o_res.length = r_length;

        case (r_phase)
            PH_HEADER: begin
                case (r_hdr_cnt)
                    HDR_FTYPE:  n_ftype  = i_byte;
                    HDR_PTYPE:  n_ptype  = i_byte;
                    HDR_LEN_LO: n_length = {{(LEN_W-BYTE_W){1'b0}}, i_byte};
                    default:    n_length = {i_byte, r_length[BYTE_W-1:0]};
                endcase
                if (r_hdr_cnt != HDR_LAST) begin
                    n_hdr_cnt = r_hdr_cnt + 2'd1;
                end else begin
                    n_hdr_cnt = '0;
                    n_remain  = n_length;
                    if (n_length == '0) begin
                        // zero-length frame gives one empty marker
                        n_phase      = PH_HUNT;
                        o_res.valid  = 1'b1;
                        o_res.empty  = 1'b1;
                        o_res.last   = 1'b1;
                        o_res.length = '0;
                    end else begin
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_remain      = r_remain - 1'b1;
                o_res.valid   = 1'b1;
                o_res.payload = i_byte;
                o_res.last    = (n_remain == '0);
                if (n_remain == '0) begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                // hunt, also taken for any unused phase code
                n_phase = PH_HUNT;
                if (r_win_cnt != WIN_FULL) begin
                    n_window  = {r_window[15:0], i_byte};
                    n_win_cnt = r_win_cnt + 2'd1;
                end else if ({r_window, i_byte} == SYNC_WORD) begin
                    n_window  = '0;
                    n_win_cnt = '0;
                    n_hdr_cnt = '0;
                    n_phase   = PH_HEADER;
                end else begin
                    n_window = {r_window[15:0], i_byte};
                end
            end
        endcase

        if (!i_fire) begin
            o_res.valid = 1'b0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_window  <= '0;
            r_win_cnt <= '0;
            r_hdr_cnt <= '0;
            r_ftype   <= '0;
            r_ptype   <= '0;
            r_length  <= '0;
            r_remain  <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_window  <= n_window;
            r_win_cnt <= n_win_cnt;
            r_hdr_cnt <= n_hdr_cnt;
            r_ftype   <= n_ftype;
            r_ptype   <= n_ptype;
            r_length  <= n_length;
            r_remain  <= n_remain;
        end
    end

endmodule

// ===== hw/rtl/swld_out_stage.sv =====
// ----------------------------------------------------------------------------
// swld_out_stage
// result register driving the outgoing stream
// ----------------------------------------------------------------------------
module swld_out_stage
    import swld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_result               i_res,
    output logic                  o_free,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data,
    output logic                  o_user,
    output logic                  o_last
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = {r_res.length, r_res.ptype, r_res.ftype, r_res.payload};
    assign o_user  = r_res.empty;
    assign o_last  = r_res.last;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res.valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_res.valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== hw/rtl/sync_word_length_deframer.sv =====
// A result is registered: it is valid on the output from the edge that accepts its request.
// Throughput: one byte per cycle while the result register can take a result; the state
// step is combinational between the input register and the result register, so a byte can follow in every cycle.
// Input is stalled only while the result register is full and not being taken.
// Reset (i_rst_n low, synchronous) empties both registers and restarts the sync hunt.
// ----------------------------------------------------------------------------
// sync_word_length_deframer
// finds the sync word, reads the frame header, marks empty frames and passes the payload bytes on
// ----------------------------------------------------------------------------
module sync_word_length_deframer
    import swld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [BYTE_W-1:0]     i_s_axis_tdata,  // rx_byte
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // payload_byte, frame_type, perception_type, frame_length
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tuser,  // is_empty_frame
    output logic                  o_m_axis_tlast
);

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              out_free;
    logic              fire;
    t_result           res;

    assign fire = in_valid && out_free;

    // input register
    swld_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_byte    (i_s_axis_tdata),
        .i_advance (out_free),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    // deframing step
    swld_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (in_byte),
        .o_res   (res)
    );

    // result register
    swld_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata),
        .o_user  (o_m_axis_tuser),
        .o_last  (o_m_axis_tlast)
    );

    // empty marker always closes the frame and carries no byte or length
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |->
            (o_m_axis_tlast && o_m_axis_tdata[7:0] == '0 &&
             o_m_axis_tdata[39:24] == '0))
        else $error("empty marker malformed");

    // a result made by the core lands in the result register
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && res.valid) |=> o_m_axis_tvalid)
        else $error("result lost");

    // input side never stalls while the result register is empty
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty result register");

endmodule
